FILE: rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// Sun tracker motor control package
// Shared types, widths, register indexes and reset values for the core.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Width of one light-sensor sample.
    localparam int unsigned SAMPLE_WIDTH = 10;

    // A sample difference needs one bit more than a sample; thresholds are 11 bits.
    localparam int unsigned DIFF_W     = SAMPLE_WIDTH + 1;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned CMP_W      = (DIFF_W > CFG_DATA_W) ? DIFF_W : CFG_DATA_W;

    localparam int unsigned REL_HIGH_W  = 10;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RIGHT_ON_LEVEL        = 3'd0,
        REG_RIGHT_VERTICAL_GUARD  = 3'd1,
        REG_LEFT_ON_LEVEL         = 3'd2,
        REG_UP_ON_LEVEL           = 3'd3,
        REG_DOWN_ON_LEVEL         = 3'd4,
        REG_RIGHT_RELEASE_LOW     = 3'd5,
        REG_UP_RELEASE_LOW        = 3'd6,
        REG_POSITIVE_RELEASE_HIGH = 3'd7
    } t_cfg_index;

    // Reset values of the thresholds, two's complement where signed.
    localparam logic [CFG_DATA_W-1:0] RST_RIGHT_ON_LEVEL       = -11'sd40;
    localparam logic [CFG_DATA_W-1:0] RST_RIGHT_VERTICAL_GUARD = 11'sd50;
    localparam logic [CFG_DATA_W-1:0] RST_LEFT_ON_LEVEL        = 11'sd50;
    localparam logic [CFG_DATA_W-1:0] RST_UP_ON_LEVEL          = -11'sd30;
    localparam logic [CFG_DATA_W-1:0] RST_DOWN_ON_LEVEL        = 11'sd50;
    localparam logic [CFG_DATA_W-1:0] RST_RIGHT_RELEASE_LOW    = -11'sd20;
    localparam logic [CFG_DATA_W-1:0] RST_UP_RELEASE_LOW       = -11'sd10;
    localparam logic [REL_HIGH_W-1:0] RST_POSITIVE_RELEASE_HIGH = 10'd20;

    // Motor bit order of the button and limit switch fields.
    localparam int unsigned BIT_RIGHT = 0;
    localparam int unsigned BIT_LEFT  = 1;
    localparam int unsigned BIT_UP    = 2;
    localparam int unsigned BIT_DOWN  = 3;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sensor_a;
        logic [SAMPLE_WIDTH-1:0] sensor_b;
        logic [SAMPLE_WIDTH-1:0] sensor_c;
        logic                    auto_mode;
        logic                    manual_mode;
        logic                    night_mode;
        logic [3:0]              manual_buttons;
        logic [3:0]              limit_switches;
    } t_in_item;

    typedef struct packed {
        logic drive_right;
        logic drive_left;
        logic drive_up;
        logic drive_down;
    } t_out_item;

    typedef struct packed {
        logic right;
        logic left;
        logic up;
        logic down;
    } t_flags;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] right_on_level;
        logic [CFG_DATA_W-1:0] right_vertical_guard;
        logic [CFG_DATA_W-1:0] left_on_level;
        logic [CFG_DATA_W-1:0] up_on_level;
        logic [CFG_DATA_W-1:0] down_on_level;
        logic [CFG_DATA_W-1:0] right_release_low;
        logic [CFG_DATA_W-1:0] up_release_low;
        logic [REL_HIGH_W-1:0] positive_release_high;
    } t_thresholds;

    // Sign-extend an 11-bit threshold to the compare width.
    function automatic logic signed [CMP_W-1:0] sext_cfg(input logic [CFG_DATA_W-1:0] x);
        return CMP_W'($signed(x));
    endfunction

    // Zero-extend an unsigned sample to a signed value at the compare width.
    function automatic logic signed [CMP_W-1:0] ext_sample(input logic [SAMPLE_WIDTH-1:0] x);
        return CMP_W'($signed({1'b0, x}));
    endfunction

endpackage

FILE: rtl/stc_cfg_regs.sv
// ----------------------------------------------------------------------------
// Threshold register file
// Holds the eight tracking thresholds, written through a plain write port.
// ----------------------------------------------------------------------------
module stc_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output stc_pkg::t_thresholds                o_thr
);
    import stc_pkg::*;

    t_thresholds r_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.right_on_level        <= RST_RIGHT_ON_LEVEL;
            r_thr.right_vertical_guard  <= RST_RIGHT_VERTICAL_GUARD;
            r_thr.left_on_level         <= RST_LEFT_ON_LEVEL;
            r_thr.up_on_level           <= RST_UP_ON_LEVEL;
            r_thr.down_on_level         <= RST_DOWN_ON_LEVEL;
            r_thr.right_release_low     <= RST_RIGHT_RELEASE_LOW;
            r_thr.up_release_low        <= RST_UP_RELEASE_LOW;
            r_thr.positive_release_high <= RST_POSITIVE_RELEASE_HIGH;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_RIGHT_ON_LEVEL:        r_thr.right_on_level       <= i_cfg_data;
                REG_RIGHT_VERTICAL_GUARD:  r_thr.right_vertical_guard <= i_cfg_data;
                REG_LEFT_ON_LEVEL:         r_thr.left_on_level        <= i_cfg_data;
                REG_UP_ON_LEVEL:           r_thr.up_on_level          <= i_cfg_data;
                REG_DOWN_ON_LEVEL:         r_thr.down_on_level        <= i_cfg_data;
                REG_RIGHT_RELEASE_LOW:     r_thr.right_release_low    <= i_cfg_data;
                REG_UP_RELEASE_LOW:        r_thr.up_release_low       <= i_cfg_data;
                REG_POSITIVE_RELEASE_HIGH: begin
                    r_thr.positive_release_high <= i_cfg_data[REL_HIGH_W-1:0];
                end
                default: ;
            endcase
        end
    end

    assign o_thr = r_thr;

endmodule

FILE: rtl/stc_control.sv
// ----------------------------------------------------------------------------
// Tracking control pass
// Forms the sensor differences, updates the four motor request flags and
// gates them with the limit switches.
// ----------------------------------------------------------------------------
module stc_control (
    input  stc_pkg::t_in_item    i_item,
    input  stc_pkg::t_thresholds i_thr,
    input  stc_pkg::t_flags      i_req,
    output stc_pkg::t_flags      o_req,
    output stc_pkg::t_out_item   o_result
);
    import stc_pkg::*;

    logic signed [CMP_W-1:0] h;
    logic signed [CMP_W-1:0] v;
    logic                    auto_en;
    logic                    h_neg;
    logic                    h_pos;
    logic                    h_pos_release;
    t_flags                  n_req;
    logic [3:0]              lim;

    assign h = ext_sample(i_item.sensor_a) - ext_sample(i_item.sensor_b);
    assign v = ext_sample(i_item.sensor_a) - ext_sample(i_item.sensor_c);

    assign auto_en       = i_item.auto_mode && !i_item.night_mode;
    assign h_neg         = h < 0;
    assign h_pos         = h > 0;
    assign h_pos_release = h_pos && (h < CMP_W'($signed({1'b0, i_thr.positive_release_high})));
    assign lim           = i_item.limit_switches;

    always_comb begin
        n_req = i_req;

        // Set rules take priority; the release rules test the horizontal difference.
        if (auto_en) begin
            if (h < sext_cfg(i_thr.right_on_level) &&
                v < sext_cfg(i_thr.right_vertical_guard)) begin
                n_req.right = 1'b1;
            end else if (h > sext_cfg(i_thr.right_release_low) && h_neg) begin
                n_req.right = 1'b0;
            end

            if (h > sext_cfg(i_thr.left_on_level)) begin
                n_req.left = 1'b1;
            end else if (h_pos_release) begin
                n_req.left = 1'b0;
            end

            if (v < sext_cfg(i_thr.up_on_level)) begin
                n_req.up = 1'b1;
            end else if (h > sext_cfg(i_thr.up_release_low) && h_neg) begin
                n_req.up = 1'b0;
            end

            if (v > sext_cfg(i_thr.down_on_level)) begin
                n_req.down = 1'b1;
            end else if (h_pos_release) begin
                n_req.down = 1'b0;
            end
        end

        if (i_item.manual_mode) begin
            n_req.right = i_item.manual_buttons[BIT_RIGHT];
            n_req.left  = i_item.manual_buttons[BIT_LEFT];
            n_req.up    = i_item.manual_buttons[BIT_UP];
            n_req.down  = i_item.manual_buttons[BIT_DOWN];
        end else if (i_item.night_mode) begin
            // Park toward left and down until the end switches close.
            n_req.left = !lim[BIT_LEFT];
            n_req.down = !lim[BIT_DOWN];
        end
    end

    assign o_req = n_req;

    assign o_result.drive_right = n_req.right && !lim[BIT_RIGHT];
    assign o_result.drive_left  = n_req.left  && !lim[BIT_LEFT];
    assign o_result.drive_up    = n_req.up    && !lim[BIT_UP];
    assign o_result.drive_down  = n_req.down  && !lim[BIT_DOWN];

endmodule

FILE: rtl/sun_tracker_motor_control_core.sv
// ----------------------------------------------------------------------------
// Sun tracker motor control core
// Dual-axis bang-bang tracker: one control pass per input transfer.
// ----------------------------------------------------------------------------
// The input channel carries one set of sensor samples, mode switches, buttons
// and limit switches per transfer; the output channel returns the four motor
// drive bits for that pass, one output transfer per input transfer, in order.
// The user must write thresholds through the configuration port only while no
// pass is in flight; the block does not enforce this. They take effect on the
// next accepted item. An accepted item waits in the input register; once the
// output register is free, the control pass runs into it, raising output valid
// and updating the request flags at the same edge. One item is taken every
// cycle while the receiver does not stall.
// When the receiver stalls, the result stays in the output register and one
// more item may wait in the input register; input ready then drops.
// Synchronous reset clears both valid bits, the request flags and restores
// the default thresholds; the block can take an item right after reset.
// ----------------------------------------------------------------------------
module sun_tracker_motor_control_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  stc_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output stc_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we,
    input  logic [stc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import stc_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in_data;
    logic        r_out_valid;
    t_out_item   r_out_data;
    t_flags      r_req;
    t_flags      n_req;
    t_out_item   n_out_data;
    t_thresholds thr;
    logic        advance;

    stc_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_thr       (thr)
    );

    stc_control u_control (
        .i_item   (r_in_data),
        .i_thr    (thr),
        .i_req    (r_req),
        .o_req    (n_req),
        .o_result (n_out_data)
    );

    // The item in the input register moves on when the output register is free.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_req       <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_req       <= n_req;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_data <= i_in_data;
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/stc_checker.sv
// ----------------------------------------------------------------------------
// Sun tracker core port checker
// Watches the core's ports for handshake and pipeline timing slips.
// ----------------------------------------------------------------------------
module stc_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_ready,
    input  logic                             o_out_valid,
    input  logic                             i_out_ready,
    input  stc_pkg::t_out_item               o_out_data,
    input  logic                             i_cfg_we
);
    logic in_xfer;

    assign in_xfer = i_in_valid && o_in_ready;

    // A result that is not taken stays valid.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped before transfer");

    // A stalled result keeps its drive bits.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output payload changed while stalled");

    // The core only refuses input while a result is held back.
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with an empty output register");

    // Output valid is high once an accepted item has passed the input register into the output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> ##2 o_out_valid)
        else $error("accepted transfer produced no result in time");

    // Configuration writes only arrive while no result waits.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> !o_out_valid)
        else $error("configuration write while a result waits");

endmodule

bind sun_tracker_motor_control_core stc_checker u_stc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data),
    .i_cfg_we    (i_cfg_we)
);

FILE: test/stc_drive_checker.sv
// ----------------------------------------------------------------------------
// Motor drive checker for the sun tracker core
// Watches the input, output and configuration ports. It keeps its own copy of
// the thresholds and request flags, predicts the drive bits of every accepted
// pass and compares them with the output transfers in order.
// ----------------------------------------------------------------------------
module stc_drive_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  stc_pkg::t_in_item                i_in_data,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  stc_pkg::t_out_item               i_out_data,
    input  logic                             i_cfg_we,
    input  logic [stc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_error_count,
    output int                               o_pending
);

    import stc_pkg::*;

    t_thresholds thr;
    t_flags      req_flags;
    t_out_item   drive_expected_q [$];
    t_out_item   drive_want;
    int          pass_no;

    string drive_name [4] = '{"drive_right", "drive_left", "drive_up", "drive_down"};

    task automatic report_error(input string msg);
        o_error_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    function automatic int as_int(input logic [CFG_DATA_W-1:0] x);
        return int'($signed(x));
    endfunction

    // One control pass: updates the request flags and returns the gated drives.
    function automatic t_out_item next_drive(input t_in_item it);
        int         h;
        int         v;
        int         rel_high;
        logic [3:0] lim;
        t_out_item  d;
        h        = int'(it.sensor_a) - int'(it.sensor_b);
        v        = int'(it.sensor_a) - int'(it.sensor_c);
        rel_high = int'(thr.positive_release_high);
        lim      = it.limit_switches;

        // Night has priority over auto; note that the up and down release
        // rules look at the horizontal difference.
        if (it.auto_mode && !it.night_mode) begin
            if (h < as_int(thr.right_on_level) && v < as_int(thr.right_vertical_guard))
                req_flags.right = 1'b1;
            else if (h > as_int(thr.right_release_low) && h < 0)
                req_flags.right = 1'b0;

            if (h > as_int(thr.left_on_level))
                req_flags.left = 1'b1;
            else if (h > 0 && h < rel_high)
                req_flags.left = 1'b0;

            if (v < as_int(thr.up_on_level))
                req_flags.up = 1'b1;
            else if (h > as_int(thr.up_release_low) && h < 0)
                req_flags.up = 1'b0;

            if (v > as_int(thr.down_on_level))
                req_flags.down = 1'b1;
            else if (h > 0 && h < rel_high)
                req_flags.down = 1'b0;
        end

        if (it.manual_mode) begin
            req_flags.right = it.manual_buttons[BIT_RIGHT];
            req_flags.left  = it.manual_buttons[BIT_LEFT];
            req_flags.up    = it.manual_buttons[BIT_UP];
            req_flags.down  = it.manual_buttons[BIT_DOWN];
        end else if (it.night_mode) begin
            req_flags.left = !lim[BIT_LEFT];
            req_flags.down = !lim[BIT_DOWN];
        end

        d.drive_right = req_flags.right && !lim[BIT_RIGHT];
        d.drive_left  = req_flags.left  && !lim[BIT_LEFT];
        d.drive_up    = req_flags.up    && !lim[BIT_UP];
        d.drive_down  = req_flags.down  && !lim[BIT_DOWN];
        return d;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr.right_on_level        = RST_RIGHT_ON_LEVEL;
            thr.right_vertical_guard  = RST_RIGHT_VERTICAL_GUARD;
            thr.left_on_level         = RST_LEFT_ON_LEVEL;
            thr.up_on_level           = RST_UP_ON_LEVEL;
            thr.down_on_level         = RST_DOWN_ON_LEVEL;
            thr.right_release_low     = RST_RIGHT_RELEASE_LOW;
            thr.up_release_low        = RST_UP_RELEASE_LOW;
            thr.positive_release_high = RST_POSITIVE_RELEASE_HIGH;
            req_flags = '0;
            drive_expected_q.delete();
            o_pending = 0;
        end else begin
            if (i_cfg_we === 1'b1) begin
                case (t_cfg_index'(i_cfg_index))
                    REG_RIGHT_ON_LEVEL:        thr.right_on_level       = i_cfg_data;
                    REG_RIGHT_VERTICAL_GUARD:  thr.right_vertical_guard = i_cfg_data;
                    REG_LEFT_ON_LEVEL:         thr.left_on_level        = i_cfg_data;
                    REG_UP_ON_LEVEL:           thr.up_on_level          = i_cfg_data;
                    REG_DOWN_ON_LEVEL:         thr.down_on_level        = i_cfg_data;
                    REG_RIGHT_RELEASE_LOW:     thr.right_release_low    = i_cfg_data;
                    REG_UP_RELEASE_LOW:        thr.up_release_low       = i_cfg_data;
                    REG_POSITIVE_RELEASE_HIGH: begin
                        thr.positive_release_high = i_cfg_data[REL_HIGH_W-1:0];
                    end
                    default: ;
                endcase
            end

            if (i_out_valid === 1'b1 && i_out_ready === 1'b1) begin
                if (drive_expected_q.size() == 0) begin
                    report_error($sformatf("output transfer %0d with no pass pending", pass_no));
                end else begin
                    drive_want = drive_expected_q.pop_front();
                    for (int i = 0; i < 4; i++) begin
                        if (i_out_data[3-i] !== drive_want[3-i])
                            report_error($sformatf("pass %0d %s got %b expected %b", pass_no,
                                                   drive_name[i], i_out_data[3-i],
                                                   drive_want[3-i]));
                    end
                end
                pass_no++;
            end

            if (i_in_valid === 1'b1 && i_in_ready === 1'b1)
                drive_expected_q.push_back(next_drive(i_in_data));

            o_pending = drive_expected_q.size();
        end
    end

endmodule

FILE: test/tb_sun_tracker_motor_control_core.sv
// ----------------------------------------------------------------------------
// Testbench for the sun tracker motor control core
// Runs directed control passes at the default thresholds, then random passes
// under several threshold settings, with random gaps on both channels and one
// long output stall. A separate checker predicts and compares the drives.
// ----------------------------------------------------------------------------
module tb_sun_tracker_motor_control_core;

    import stc_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 200;
    localparam int SAMPLE_MAX   = (1 << SAMPLE_WIDTH) - 1;

    logic                   i_clk;
    logic                   i_rst_n   = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    t_in_item               in_data   = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    t_out_item              out_data;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int fail_count;
    int pass_pending;
    int cycle_count;
    int thr_plan [8];
    bit tx_calm;
    bit rx_calm;
    bit hold_request;

    sun_tracker_motor_control_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    stc_drive_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_data    (out_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_error_count (fail_count),
        .o_pending     (pass_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item pass_item(input int a, input int b, input int c,
                                           input bit au, input bit ma, input bit ni,
                                           input logic [3:0] bt, input logic [3:0] lm);
        t_in_item it;
        it.sensor_a       = SAMPLE_WIDTH'(a);
        it.sensor_b       = SAMPLE_WIDTH'(b);
        it.sensor_c       = SAMPLE_WIDTH'(c);
        it.auto_mode      = au;
        it.manual_mode    = ma;
        it.night_mode     = ni;
        it.manual_buttons = bt;
        it.limit_switches = lm;
        return it;
    endfunction

    function automatic logic [SAMPLE_WIDTH-1:0] near(input int base, input int span);
        int x;
        x = base + int'($urandom_range(0, 2 * span)) - span;
        if (x < 0)
            x = 0;
        else if (x > SAMPLE_MAX)
            x = SAMPLE_MAX;
        return SAMPLE_WIDTH'(x);
    endfunction

    // Samples cluster around sensor_a so the differences sit near the levels.
    function automatic t_in_item random_pass();
        t_in_item it;
        int       a;
        int       span;
        int       r;
        a = $urandom_range(0, SAMPLE_MAX);
        case ($urandom_range(0, 3))
            0:       span = 30;
            1:       span = 80;
            2:       span = 300;
            default: span = SAMPLE_MAX;
        endcase
        it.sensor_a       = SAMPLE_WIDTH'(a);
        it.sensor_b       = near(a, span);
        it.sensor_c       = near(a, span);
        it.manual_buttons = 4'($urandom);
        it.limit_switches = ($urandom_range(0, 99) < 65) ? 4'h0 : 4'($urandom);
        r = $urandom_range(0, 99);
        it.auto_mode   = 1'b0;
        it.manual_mode = 1'b0;
        it.night_mode  = 1'b0;
        if (r < 55) begin
            it.auto_mode = 1'b1;
        end else if (r < 65) begin
            it.manual_mode = 1'b1;
            it.auto_mode   = 1'($urandom);
        end else if (r < 75) begin
            it.night_mode = 1'b1;
            it.auto_mode  = 1'($urandom);
        end else if (r < 90) begin
            it.auto_mode   = 1'($urandom);
            it.manual_mode = 1'($urandom);
            it.night_mode  = 1'($urandom);
        end
        return it;
    endfunction

    function automatic int random_level();
        if ($urandom_range(0, 99) < 70)
            return int'($urandom_range(0, 400)) - 200;
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    task automatic plan_random_thresholds();
        for (int i = 0; i < 5; i++)
            thr_plan[i] = random_level();
        thr_plan[5] = -int'($urandom_range(0, 300));
        thr_plan[6] = -int'($urandom_range(0, 300));
        thr_plan[7] = $urandom_range(0, 300);
    endtask

    task automatic load_thresholds();
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= t_cfg_index'(i);
            cfg_data  <= CFG_DATA_W'(thr_plan[i]);
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_pass(input t_in_item it);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_ready !== 1'b1);
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
            send_pass(random_pass());
    endtask

    // Let every pending pass come out before touching the thresholds.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pass_pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            int n;
            if (hold_request) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                n = rx_calm ? 0 : pick_gap();
                if (n > 0) begin
                    out_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Default thresholds: extremes, set and release edges, every mode mix but all three modes at once.
        send_pass(pass_item(1023,    0,    0, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item(   0, 1023, 1023, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item(  10,   15,   10, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item(  15,   10,   15, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item(   0,    0,    0, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  541,  450, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  540,  449, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  541,  451, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  450,  450, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  449,  449, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  530,  531, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  520,  530, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  519,  530, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  510,  530, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  509,  500, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  480,  500, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item( 500,  481,  500, 1, 0, 0, 4'h0, 4'h0));
        send_pass(pass_item(   0,    0,    0, 0, 1, 0, 4'hF, 4'h0));
        send_pass(pass_item(   0,    0,    0, 0, 1, 0, 4'hF, 4'hF));
        send_pass(pass_item(1023,    0, 1023, 1, 1, 0, 4'h5, 4'h0));
        send_pass(pass_item(   0,    0,    0, 0, 1, 1, 4'hA, 4'h2));
        send_pass(pass_item(   0,    0,    0, 0, 0, 1, 4'h0, 4'h0));
        send_pass(pass_item(1023,    0,    0, 1, 0, 1, 4'h0, 4'hA));
        send_pass(pass_item(1023, 1023, 1023, 0, 0, 0, 4'hF, 4'h5));
        run_random(100);
        settle();

        // All levels at the negative end, release high at zero; no idling.
        thr_plan = '{-1024, -1024, -1024, -1024, -1024, -1024, -1024, 0};
        load_thresholds();
        tx_calm = 1'b1;
        rx_calm = 1'b1;
        run_random(80);
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        settle();

        // Positive end; the top data bit on the release high register is ignored.
        thr_plan = '{1023, 1023, 1023, 1023, 1023, 1023, 1023, 2047};
        load_thresholds();
        run_random(80);
        settle();

        thr_plan = '{1023, -1024, -1024, 1023, -1024, 0, 0, 1023};
        load_thresholds();
        run_random(80);
        settle();

        // Levels in inverted relations to one another.
        thr_plan = '{40, -50, -50, 30, -50, -1, -1, 1};
        load_thresholds();
        run_random(80);
        settle();

        // Long output stall while input keeps coming, so the core backs up.
        plan_random_thresholds();
        load_thresholds();
        hold_request = 1'b1;
        tx_calm      = 1'b1;
        run_random(30);
        tx_calm = 1'b0;
        run_random(65);
        settle();

        for (int p = 0; p < 2; p++) begin
            plan_random_thresholds();
            load_thresholds();
            run_random(95);
            settle();
        end

        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pass_pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/stc_pkg.sv
rtl/stc_cfg_regs.sv
rtl/stc_control.sv
rtl/sun_tracker_motor_control_core.sv
rtl/stc_checker.sv
test/stc_drive_checker.sv
test/tb_sun_tracker_motor_control_core.sv
